>>> src/lmsf_pkg.sv
`default_nettype none

package lmsf_pkg;

  localparam int unsigned DATA_W     = 16;
  localparam int unsigned MAG_W      = 15;
  localparam int unsigned TAPCFG_W   = 6;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [MAG_W-1:0]    LR_RESET     = 15'd328;
  localparam logic [MAG_W-1:0]    TARGET_RESET = 15'd33;
  localparam logic [MAG_W-1:0]    MAXERR_RESET = 15'd3277;
  localparam logic [TAPCFG_W-1:0] TAPS_RESET   = 6'd32;
  localparam logic [DATA_W-1:0]   OFFSET_RESET = 16'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEARNING_RATE = 3'd0,
    REG_TARGET_ERROR  = 3'd1,
    REG_MAX_ERROR     = 3'd2,
    REG_TAP_COUNT     = 3'd3,
    REG_START_OFFSET  = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    OUT_RUNNING   = 3'd0,
    OUT_CONVERGED = 3'd1,
    OUT_END_OK    = 3'd2,
    OUT_END_FAIL  = 3'd3,
    OUT_IGNORED   = 3'd4
  } outcome_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] x_sample;
    logic signed [DATA_W-1:0] d_sample;
    logic                     first_of_run;
    logic                     last_of_run;
  } in_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] error_value;
    logic [MAG_W-1:0]         average_error;
    logic [2:0]               outcome;
    logic [MAG_W-1:0]         final_error;
  } out_rsp_t;

endpackage

`default_nettype wire

>>> src/lmsf_ram.sv
`default_nettype none

module lmsf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> src/lms_adaptive_fir_q15.sv
`default_nettype none
// An item walks every active tap once for the estimate and once for the update; an item
//   arriving after the run has ended goes straight to the answer state without the taps.
// One item at a time: a new item is taken only once the last result has been handed
//   on; the pace is set by the single shared 16x16 multiplier (one product per tap for
//   the estimate, two per tap for the update) and the one read port of each tap memory.
// Reset: asynchronous, active low; taps and delay line read as zero through valid
//   bits, control and configuration registers take their reset values, no clearing pass.

module lms_adaptive_fir_q15 #(
  parameter int unsigned MAX_TAPS = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire lmsf_pkg::in_req_t                   in_req_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output lmsf_pkg::out_rsp_t                       out_rsp_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [lmsf_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [lmsf_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  import lmsf_pkg::*;

  localparam int unsigned AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int unsigned TW = $clog2(MAX_TAPS + 1);
  localparam int unsigned CW = (TW > TAPCFG_W) ? TW : TAPCFG_W;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_ERD  = 10'b0000000010,
    S_EMUL = 10'b0000000100,
    S_ERR  = 10'b0000001000,
    S_CHK  = 10'b0000010000,
    S_URD  = 10'b0000100000,
    S_UM1  = 10'b0001000000,
    S_UM2  = 10'b0010000000,
    S_UWR  = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [MAG_W-1:0]    lr_q, target_q, maxerr_q;
  logic [TAPCFG_W-1:0] tapcfg_q;
  logic [DATA_W-1:0]   offset_q;

  // run state
  logic [MAG_W-1:0]  avg_q;
  logic [DATA_W-1:0] sample_index_q;
  logic              finished_q;

  // per-item working registers
  in_req_t                  req_q;
  logic [TW-1:0]            taps_q;
  logic [TW-1:0]            m_q;
  logic [DATA_W-1:0]        item_idx_q;
  logic signed [DATA_W-1:0] acc_q;
  logic signed [DATA_W-1:0] prod_q;
  logic signed [DATA_W-1:0] err_q;
  logic signed [DATA_W-1:0] w_hold_q;
  logic signed [DATA_W-1:0] dlh_q;
  logic signed [DATA_W-1:0] prev_q;
  logic                     w_ok_q, dl_ok_q, use_x_q;
  out_rsp_t                 rsp_q;
  out_rsp_t                 out_q;
  logic                     out_valid_q;
  logic [MAX_TAPS-1:0]      w_vld_q, dl_vld_q;

  // effective tap count of the incoming item
  logic [CW-1:0] tc_ext;
  logic [TW-1:0] taps_eff;
  always_comb begin
    tc_ext = CW'(tapcfg_q);
    if (tc_ext == '0) begin
      taps_eff = TW'(1);
    end else if (tc_ext > CW'(MAX_TAPS)) begin
      taps_eff = TW'(MAX_TAPS);
    end else begin
      taps_eff = TW'(tc_ext);
    end
  end

  logic          is_last;
  logic [TW-1:0] m_next;
  logic [TW-1:0] rd_sel;
  logic [AW-1:0] rd_addr;
  logic          ram_re;

  assign is_last = (m_q == taps_q - TW'(1));
  assign m_next  = m_q + TW'(1);
  assign rd_sel  = (state_q == S_UWR) ? m_next : m_q;
  assign rd_addr = rd_sel[AW-1:0];
  assign ram_re  = (state_q == S_ERD) || (state_q == S_URD) ||
                   ((state_q == S_UWR) && !is_last);

  // tap memories
  logic [DATA_W-1:0] w_rd, dl_rd;
  logic              w_we, dl_we;
  logic [DATA_W-1:0] w_wdata;

  assign w_we    = (state_q == S_UWR);
  assign dl_we   = (state_q == S_UWR) && (m_q != '0);
  assign w_wdata = DATA_W'(w_hold_q + prod_q);

  lmsf_ram #(.WIDTH(DATA_W), .DEPTH(MAX_TAPS)) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (m_q[AW-1:0]),
    .wdata_i (w_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_addr),
    .rdata_o (w_rd)
  );

  lmsf_ram #(.WIDTH(DATA_W), .DEPTH(MAX_TAPS)) u_delay_ram (
    .clk_i   (clk_i),
    .we_i    (dl_we),
    .waddr_i (m_q[AW-1:0]),
    .wdata_i (prev_q),
    .re_i    (ram_re),
    .raddr_i (rd_addr),
    .rdata_o (dl_rd)
  );

  // tap operands; the head of the delay line is the incoming sample
  logic signed [DATA_W-1:0] w_eff, dl_eff;
  assign w_eff  = w_ok_q ? $signed(w_rd) : '0;
  assign dl_eff = use_x_q ? req_q.x_sample : (dl_ok_q ? $signed(dl_rd) : '0);

  // shared Q15 multiplier: floor shift by 15, keep 16 bits
  logic signed [DATA_W-1:0]   op_a, op_b;
  logic signed [2*DATA_W-1:0] mul_full;
  logic signed [DATA_W-1:0]   qmul;

  always_comb begin
    case (state_q)
      S_UM1: begin
        op_a = dl_eff;
        op_b = err_q;
      end
      S_UM2: begin
        op_a = $signed({1'b0, lr_q});
        op_b = prod_q;
      end
      default: begin
        op_a = w_eff;
        op_b = dl_eff;
      end
    endcase
  end

  assign mul_full = (2*DATA_W)'(op_a) * (2*DATA_W)'(op_b);
  assign qmul     = mul_full[30:15];

  // error, magnitude, average and end-of-run decision
  logic signed [DATA_W-1:0] est;
  logic [DATA_W-1:0]        err_neg;
  logic [MAG_W-1:0]         mag;
  logic [MAG_W:0]           avg_sum;
  logic [MAG_W-1:0]         avg_new;
  logic                     conv;

  assign est     = DATA_W'(acc_q + prod_q);
  assign err_neg = DATA_W'(-err_q);
  always_comb begin
    if (!err_q[DATA_W-1]) begin
      mag = err_q[MAG_W-1:0];
    end else if (err_q == 16'sh8000) begin
      mag = '1;
    end else begin
      mag = err_neg[MAG_W-1:0];
    end
  end
  assign avg_sum = {1'b0, avg_q} + {1'b0, mag};
  assign avg_new = avg_sum[MAG_W:1];
  assign conv    = (avg_new <= target_q) && (item_idx_q > DATA_W'(taps_q >> 2));

  logic out_free;
  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (!in_req_i.first_of_run && finished_q) begin
            state_d = S_DONE;
          end else begin
            state_d = S_ERD;
          end
        end
      end
      S_ERD:  state_d = S_EMUL;
      S_EMUL: state_d = is_last ? S_ERR : S_ERD;
      S_ERR:  state_d = S_CHK;
      S_CHK:  state_d = S_URD;
      S_URD:  state_d = S_UM1;
      S_UM1:  state_d = S_UM2;
      S_UM2:  state_d = S_UWR;
      S_UWR:  state_d = is_last ? S_DONE : S_UM1;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control and run state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      lr_q           <= LR_RESET;
      target_q       <= TARGET_RESET;
      maxerr_q       <= MAXERR_RESET;
      tapcfg_q       <= TAPS_RESET;
      offset_q       <= OFFSET_RESET;
      avg_q          <= '0;
      sample_index_q <= '0;
      finished_q     <= 1'b0;
      m_q            <= '0;
      w_vld_q        <= '0;
      dl_vld_q       <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_LEARNING_RATE: lr_q     <= cfg_data_i[MAG_W-1:0];
          REG_TARGET_ERROR:  target_q <= cfg_data_i[MAG_W-1:0];
          REG_MAX_ERROR:     maxerr_q <= cfg_data_i[MAG_W-1:0];
          REG_TAP_COUNT:     tapcfg_q <= cfg_data_i[TAPCFG_W-1:0];
          REG_START_OFFSET:  offset_q <= cfg_data_i;
          default: ;
        endcase
      end

      if ((state_q == S_IDLE) && in_valid_i && in_req_i.first_of_run) begin
        avg_q      <= '0;
        finished_q <= 1'b0;
      end

      if ((state_q == S_IDLE) || (state_q == S_CHK)) begin
        m_q <= '0;
      end else if (((state_q == S_EMUL) || (state_q == S_UWR)) && !is_last) begin
        m_q <= m_next;
      end

      if (state_q == S_CHK) begin
        avg_q          <= avg_new;
        sample_index_q <= item_idx_q + DATA_W'(1);
        if (conv || req_q.last_of_run) begin
          finished_q <= 1'b1;
        end
      end

      if (w_we) begin
        w_vld_q[m_q[AW-1:0]] <= 1'b1;
      end
      if (dl_we) begin
        dl_vld_q[m_q[AW-1:0]] <= 1'b1;
      end

      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) && in_valid_i) begin
      req_q      <= in_req_i;
      taps_q     <= taps_eff;
      acc_q      <= '0;
      item_idx_q <= in_req_i.first_of_run ? offset_q : sample_index_q;
      // ended run: answer without touching anything
      rsp_q.error_value   <= '0;
      rsp_q.average_error <= avg_q;
      rsp_q.outcome       <= OUT_IGNORED;
      rsp_q.final_error   <= '0;
    end

    if (ram_re) begin
      w_ok_q  <= w_vld_q[rd_addr];
      dl_ok_q <= dl_vld_q[rd_addr];
      use_x_q <= (rd_sel == '0);
    end

    if ((state_q == S_ERD) && (m_q != '0)) begin
      acc_q <= DATA_W'(acc_q + prod_q);
    end

    if ((state_q == S_EMUL) || (state_q == S_UM1) || (state_q == S_UM2)) begin
      prod_q <= qmul;
    end

    if (state_q == S_ERR) begin
      err_q <= DATA_W'(req_q.d_sample - est);
    end

    if (state_q == S_CHK) begin
      rsp_q.error_value   <= err_q;
      rsp_q.average_error <= avg_new;
      if (conv) begin
        rsp_q.outcome     <= OUT_CONVERGED;
        rsp_q.final_error <= '0;
      end else if (req_q.last_of_run) begin
        rsp_q.outcome     <= (mag <= maxerr_q) ? OUT_END_OK : OUT_END_FAIL;
        rsp_q.final_error <= mag;
      end else begin
        rsp_q.outcome     <= OUT_RUNNING;
        rsp_q.final_error <= '0;
      end
    end

    if (state_q == S_UM1) begin
      w_hold_q <= w_eff;
      dlh_q    <= dl_eff;
    end

    // shift the delay line one place as the taps go by
    if (state_q == S_UWR) begin
      prev_q <= dlh_q;
    end

    if ((state_q == S_DONE) && out_free) begin
      out_q <= rsp_q;
    end
  end

endmodule

`default_nettype wire
